// ===== src/fixed_point_atan2_degrees_core_assert.svh =====
// -----------------------------------------------------------------------------
// fixed_point_atan2_degrees_core assertion macros
// Property checks clocked on i_clk and disabled while i_rst_n is low.
// -----------------------------------------------------------------------------
`ifndef FIXED_POINT_ATAN2_DEGREES_CORE_ASSERT_SVH
`define FIXED_POINT_ATAN2_DEGREES_CORE_ASSERT_SVH

// Same-cycle implication
`define FPA2D_CHK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fpa2d check failed");

// Next-cycle implication
`define FPA2D_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fpa2d check failed");

`endif

// ===== src/fpa2d_pkg.sv =====
// -----------------------------------------------------------------------------
// fpa2d_pkg
// Shared types and constants of the atan2 degree core.
// -----------------------------------------------------------------------------
package fpa2d_pkg;

    // Angle arithmetic width, covers -256..255 plus headroom
    localparam int AngleW = 10;

    localparam logic signed [AngleW-1:0] BasePosX   = 10'sd45;
    localparam logic signed [AngleW-1:0] BaseNegX   = 10'sd135;
    localparam logic signed [AngleW-1:0] AngleLimit = 10'sd180;
    localparam logic signed [AngleW-1:0] AngleZero  = 10'sd0;

    localparam int LinearCoeff = 56;  // applied with negative sign
    localparam int CubicCoeff  = 11;

    // Flags that travel with a word through the divider cells
    typedef struct packed {
        logic y_zero;
        logic y_neg;
        logic x_neg;
        logic r_neg;
    } t_side;

endpackage

// ===== src/fpa2d_div_cell.sv =====
// -----------------------------------------------------------------------------
// fpa2d_div_cell
// One restoring-division step: compare, subtract, shift, append a quotient bit.
// -----------------------------------------------------------------------------
module fpa2d_div_cell
    import fpa2d_pkg::*;
#(
    parameter int QW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [17:0]          i_rem,
    input  logic [16:0]          i_den,
    input  logic [QW-1:0]        i_quo,
    input  t_side                i_side,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [17:0]          o_rem,
    output logic [16:0]          o_den,
    output logic [QW-1:0]        o_quo,
    output t_side                o_side
);

    logic          r_valid;
    logic          n_valid;
    logic [17:0]   r_rem;
    logic [16:0]   r_den;
    logic [QW-1:0] r_quo;
    t_side         r_side;

    logic          load;
    logic          bit_q;
    logic [17:0]   rem_d;

    assign o_stall = r_valid && i_stall;
    assign load    = !o_stall;

    always_comb begin
        bit_q   = (i_rem >= {1'b0, i_den});
        rem_d   = bit_q ? (i_rem - {1'b0, i_den}) : i_rem;
        n_valid = load ? i_valid : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Remainder stays below the divisor after the subtract, so the shift fits
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rem  <= {rem_d[16:0], 1'b0};
            r_den  <= i_den;
            r_quo  <= {i_quo[QW-2:0], bit_q};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule

// ===== src/fpa2d_poly.sv =====
// -----------------------------------------------------------------------------
// fpa2d_poly
// Cubic polynomial on the ratio, quadrant base, sign and clamp; four stages.
// -----------------------------------------------------------------------------
module fpa2d_poly
    import fpa2d_pkg::*;
#(
    parameter int FRACTION_BITS = 15
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [FRACTION_BITS:0]     i_quo,
    input  t_side                      i_side,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [8:0]          o_angle
);

    localparam int RW = FRACTION_BITS + 2;
    localparam int PW = 2 * RW;
    localparam int SW = RW + 8;
    localparam logic signed [SW-1:0] KCub = SW'(CubicCoeff);
    localparam logic signed [SW-1:0] KLin = SW'(LinearCoeff);

    logic [3:0]  r_valid;
    logic [3:0]  n_valid;
    logic [3:0]  stall;
    logic [3:0]  load;

    logic signed [RW-1:0] r_r1, r_r2, r_r3;
    logic signed [RW-1:0] r_sq;
    logic signed [RW-1:0] r_cube;
    t_side                r_side1, r_side2, r_side3;
    logic signed [8:0]    r_angle;

    logic signed [RW-1:0]     r_in;
    logic signed [PW-1:0]     prod_sq;
    logic signed [PW-1:0]     prod_cube;
    logic signed [SW-1:0]     poly_sum;
    logic signed [SW-1:0]     poly_shift;
    logic signed [AngleW-1:0] base;
    logic signed [AngleW-1:0] mag;
    logic signed [AngleW-1:0] angle;

    // Stall ripples back from the output register
    always_comb begin
        stall[3] = r_valid[3] && i_stall;
        stall[2] = r_valid[2] && stall[3];
        stall[1] = r_valid[1] && stall[2];
        stall[0] = r_valid[0] && stall[1];
        load     = ~stall;
        n_valid[0] = load[0] ? i_valid    : r_valid[0];
        n_valid[1] = load[1] ? r_valid[0] : r_valid[1];
        n_valid[2] = load[2] ? r_valid[1] : r_valid[2];
        n_valid[3] = load[3] ? r_valid[2] : r_valid[3];
    end

    assign o_stall = stall[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_comb begin
        r_in      = i_side.r_neg ? -$signed({1'b0, i_quo}) : $signed({1'b0, i_quo});
        prod_sq   = PW'(r_r1) * PW'(r_r1);
        prod_cube = PW'(r_sq) * PW'(r_r2);
        poly_sum  = KCub * SW'(r_cube) - KLin * SW'(r_r3);
        poly_shift = poly_sum >>> FRACTION_BITS;
        base      = r_side3.x_neg ? BaseNegX : BasePosX;
        mag       = base + poly_shift[AngleW-1:0];
        if (r_side3.y_zero) begin
            angle = r_side3.x_neg ? AngleLimit : AngleZero;
        end else if (r_side3.y_neg) begin
            angle = -mag;
        end else begin
            angle = mag;
        end
        if (angle > AngleLimit) begin
            angle = AngleLimit;
        end else if (angle < -AngleLimit) begin
            angle = -AngleLimit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load[0]) begin
            r_r1    <= r_in;
            r_side1 <= i_side;
        end
        if (load[1]) begin
            r_sq    <= prod_sq[FRACTION_BITS +: RW];
            r_r2    <= r_r1;
            r_side2 <= r_side1;
        end
        if (load[2]) begin
            r_cube  <= prod_cube[FRACTION_BITS +: RW];
            r_r3    <= r_r2;
            r_side3 <= r_side2;
        end
        if (load[3]) begin
            r_angle <= angle[8:0];
        end
    end

    assign o_valid = r_valid[3];
    assign o_angle = r_angle;

endmodule

// ===== src/fixed_point_atan2_degrees_core.sv =====
// -----------------------------------------------------------------------------
// fixed_point_atan2_degrees_core
// atan2(y, x) in whole degrees, -180..180, by a cubic polynomial on a ratio.
// -----------------------------------------------------------------------------
// The core takes one (y, x) word per cycle while o_in_stall is low and returns
// one angle word for each, in order. A word passes through the row of
// FRACTION_BITS + 1 restoring division cells, one quotient bit per cell,
// and then four stages for the square, the cube, and the polynomial with
// sign and clamp. A stall on the output holds only the occupied stages, so
// bubbles inside the pipe still close.
`include "fixed_point_atan2_degrees_core_assert.svh"

module fixed_point_atan2_degrees_core
    import fpa2d_pkg::*;
#(
    parameter int FRACTION_BITS = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic signed [15:0] i_y_value,
    input  logic signed [15:0] i_x_value,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic signed [8:0] o_angle_degrees
);

    localparam int QW    = FRACTION_BITS + 1;
    localparam int Cells = FRACTION_BITS + 1;

    logic [16:0]        abs_y;
    logic signed [17:0] num;
    logic signed [17:0] den;
    logic [16:0]        abs_num;
    t_side              side_in;

    logic [Cells:0]       c_valid;
    logic [Cells:0]       c_stall;
    logic [17:0]          c_rem  [Cells+1];
    logic [16:0]          c_den  [Cells+1];
    logic [QW-1:0]        c_quo  [Cells+1];
    t_side                c_side [Cells+1];

    // Fold the vector into a signed numerator over a non-negative divisor
    always_comb begin
        abs_y = i_y_value[15] ? (17'd0 - {i_y_value[15], i_y_value})
                              : {1'b0, i_y_value};
        if (i_x_value[15]) begin
            num = 18'(i_x_value) + $signed({1'b0, abs_y});
            den = $signed({1'b0, abs_y}) - 18'(i_x_value);
        end else begin
            num = 18'(i_x_value) - $signed({1'b0, abs_y});
            den = 18'(i_x_value) + $signed({1'b0, abs_y});
        end
        abs_num = num[17] ? 17'(-num) : num[16:0];
        side_in.y_zero = (i_y_value == 16'sd0);
        side_in.y_neg  = i_y_value[15];
        side_in.x_neg  = i_x_value[15];
        side_in.r_neg  = num[17];
    end

    assign c_valid[0]  = i_in_valid;
    assign o_in_stall  = c_stall[0];
    assign c_rem[0]    = {1'b0, abs_num};
    assign c_den[0]    = den[16:0];
    assign c_quo[0]    = '0;
    assign c_side[0]   = side_in;

    for (genvar k = 0; k < Cells; k++) begin : g_cell
        fpa2d_div_cell #(
            .QW (QW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_stall (c_stall[k]),
            .i_rem   (c_rem[k]),
            .i_den   (c_den[k]),
            .i_quo   (c_quo[k]),
            .i_side  (c_side[k]),
            .o_valid (c_valid[k+1]),
            .i_stall (c_stall[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_den   (c_den[k+1]),
            .o_quo   (c_quo[k+1]),
            .o_side  (c_side[k+1])
        );
    end

    fpa2d_poly #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[Cells]),
        .o_stall (c_stall[Cells]),
        .i_quo   (c_quo[Cells]),
        .i_side  (c_side[Cells]),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_angle (o_angle_degrees)
    );

    `FPA2D_CHK_NOW(a_angle_range, o_out_valid, (o_angle_degrees <= 9'sd180) && (o_angle_degrees >= -9'sd180))
    `FPA2D_CHK_NOW(a_stall_source, o_in_stall, o_out_valid && i_out_stall)
    `FPA2D_CHK_NEXT(a_stall_drains, o_out_valid && !i_out_stall && !c_valid[Cells], !o_in_stall)

endmodule

// ===== tb/sv/tb.sv =====
// -----------------------------------------------------------------------------
// tb: atan2 degree core testbench
// Feeds (y, x) words through the valid/stall input channel and predicts the
// degree angle of each word. Each returned word is compared in order with the
// prediction. Both channels idle and stall at random, and one phase runs at
// full rate.
// -----------------------------------------------------------------------------
module tb;

    localparam int      FracBits  = 15;
    localparam int      PipeDepth = FracBits + 5;
    localparam longint  OneQ      = longint'(1) << FracBits;
    localparam longint  LinCoeff  = -56;
    localparam longint  CubCoeff  = 11;
    localparam longint  BaseRight = 45;
    localparam longint  BaseLeft  = 135;
    localparam longint  MaxDeg    = 180;
    localparam int      ShowLimit = 10;

    // Shapes of random vectors
    typedef enum int {
        SHAPE_FULL,
        SHAPE_SMALL,
        SHAPE_EXTREME,
        SHAPE_DIAGONAL,
        SHAPE_AXIS_Y,
        SHAPE_AXIS_X
    } t_shape;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_in_valid      = 1'b0;
    logic signed [15:0] i_y_value      = '0;
    logic signed [15:0] i_x_value      = '0;
    logic              i_out_stall     = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic signed [8:0] o_angle_degrees;

    logic signed [8:0] expected_angles[$];
    logic signed [8:0] want_angle;
    int                send_idle_pct  = 27;
    int                stall_pct      = 27;
    int                mismatch_count = 0;
    int                angle_count    = 0;
    int                zero_y_count   = 0;
    int                left_count     = 0;
    int                lower_count    = 0;

    fixed_point_atan2_degrees_core #(
        .FRACTION_BITS(FracBits)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_y_value      (i_y_value),
        .i_x_value      (i_x_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_angle_degrees(o_angle_degrees)
    );

    always #4 i_clk = ~i_clk;

    // Fold the vector into a ratio in [-1, 1], then apply the cubic
    function automatic logic signed [8:0] atan2_degrees(input logic signed [15:0] y,
                                                         input logic signed [15:0] x);
        longint yv, xv, ay, num, den, base, ratio, cube, angle;
        yv = y;
        xv = x;
        ay = (yv < 0) ? -yv : yv;
        if (yv == 0) begin
            angle = (xv >= 0) ? 0 : MaxDeg;
        end else begin
            if (xv >= 0) begin
                num  = xv - ay;
                den  = xv + ay;
                base = BaseRight;
            end else begin
                num  = xv + ay;
                den  = ay - xv;
                base = BaseLeft;
            end
            ratio = (num * OneQ) / den;
            cube  = (ratio * ratio) >>> FracBits;
            cube  = (cube * ratio) >>> FracBits;
            angle = base + ((LinCoeff * ratio + CubCoeff * cube) >>> FracBits);
        end
        if (yv < 0) angle = -angle;
        if (angle > MaxDeg) angle = MaxDeg;
        if (angle < -MaxDeg) angle = -MaxDeg;
        return angle[8:0];
    endfunction

    function automatic logic signed [15:0] pick_component(input t_shape shape);
        logic signed [15:0] corners[7];
        corners = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7ffe, 16'sh7fff};
        case (shape)
            SHAPE_SMALL:   return 16'(int'($urandom_range(128)) - 64);
            SHAPE_EXTREME: return corners[$urandom_range(6)];
            default:       return 16'($urandom);
        endcase
    endfunction

    // Retire result words and drive the output stall for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_angles.size() == 0) begin
                if (mismatch_count < ShowLimit)
                    $display("unexpected angle word %0d", o_angle_degrees);
                mismatch_count++;
            end else begin
                want_angle = expected_angles.pop_front();
                angle_count++;
                if (o_angle_degrees !== want_angle) begin
                    if (mismatch_count < ShowLimit)
                        $display("angle mismatch: expected %0d, got %0d",
                                 want_angle, o_angle_degrees);
                    mismatch_count++;
                end
            end
        end
        i_out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    task automatic send_vector(input logic signed [15:0] y, input logic signed [15:0] x);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_y_value  <= y;
        i_x_value  <= x;
        @(posedge i_clk);
        while (!(i_in_valid && !o_in_stall)) @(posedge i_clk);
        expected_angles.push_back(atan2_degrees(y, x));
        if (y == 0) zero_y_count++;
        if (x < 0) left_count++;
        if (y < 0) lower_count++;
    endtask

    // Hold the input idle until every predicted word has come back
    task automatic wait_for_angles();
        i_in_valid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_vectors();
        send_vector(16'sd0, 16'sd0);
        send_vector(16'sd0, 16'sh7fff);
        send_vector(16'sd0, -16'sd1);
        send_vector(16'sd0, 16'sh8000);
        send_vector(16'sh8000, 16'sh8000);
        send_vector(16'sh8000, 16'sh7fff);
        send_vector(16'sh8000, 16'sd0);
        send_vector(16'sh7fff, 16'sh8000);
        send_vector(16'sh7fff, 16'sh7fff);
        send_vector(16'sh7fff, 16'sd0);
        send_vector(16'sd1, 16'sd0);
        send_vector(-16'sd1, 16'sd0);
        send_vector(16'sd1, 16'sh8000);
        send_vector(-16'sd1, 16'sh8000);
        send_vector(16'sd1, 16'sh7fff);
        send_vector(-16'sd1, 16'sh7fff);
        send_vector(16'sh8000, 16'sd1);
        send_vector(16'sd100, 16'sd100);
        send_vector(-16'sd100, -16'sd100);
        send_vector(16'sd5, -16'sd5);
        send_vector(-16'sd5, 16'sd5);
        send_vector(16'sd1, 16'sd1);
        send_vector(16'sh7fff, 16'sd1);
        send_vector(-16'sd32767, -16'sd1);
    endtask

    task automatic test_mixed_vectors(input int count);
        t_shape             shape;
        logic signed [15:0] y, x;
        repeat (count) begin
            shape = t_shape'($urandom_range(SHAPE_AXIS_X));
            y = pick_component(shape);
            x = pick_component(shape);
            if (shape == SHAPE_DIAGONAL) y = $urandom_range(1) ? x : -x;
            if (shape == SHAPE_AXIS_Y) y = '0;
            if (shape == SHAPE_AXIS_X) x = '0;
            send_vector(y, x);
        end
    endtask

    // Long stretch with neither side idling
    task automatic test_full_rate(input int count);
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (count) send_vector(16'($urandom), 16'($urandom));
        send_idle_pct = 27;
        stall_pct     = 27;
    endtask

    task automatic test_small_magnitudes(input int count);
        logic signed [15:0] y, x;
        repeat (count) begin
            y = pick_component(SHAPE_SMALL);
            x = pick_component(SHAPE_SMALL);
            if ($urandom_range(3) == 0) y = $urandom_range(1) ? x : -x;
            send_vector(y, x);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_vectors();
        test_mixed_vectors(700);
        wait_for_angles();
        test_full_rate(350);
        test_small_magnitudes(300);
        wait_for_angles();
        repeat (PipeDepth + 8) @(posedge i_clk);
        $display("checked %0d angle words: %0d with zero y, %0d with negative x, %0d with negative y",
                 angle_count, zero_y_count, left_count, lower_count);
        $display("%0d mismatches", mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS fixed_point_atan2_degrees_core");
        end else begin
            $display("FAIL fixed_point_atan2_degrees_core");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout with %0d angle words outstanding", expected_angles.size());
        $display("FAIL fixed_point_atan2_degrees_core");
        $finish;
    end

endmodule

// ===== fixed_point_atan2_degrees_core.f =====
+incdir+src
src/fpa2d_pkg.sv
src/fpa2d_div_cell.sv
src/fpa2d_poly.sv
src/fixed_point_atan2_degrees_core.sv
tb/sv/tb.sv
